// ===== rtl/cln_pkg.sv =====
// Shared types and constants for the character LCD 4-bit interface block.
// Depends on nothing; used by cln_if.sv, cln_seq.sv and the top level.
`default_nettype none

package cln_pkg;

    // Field widths
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COL_W    = 6;
    localparam int unsigned ROW_W    = 2;
    localparam int unsigned NIB_W    = 4;
    localparam int unsigned WAIT_W   = 14;
    localparam int unsigned LONG_W   = 12;
    localparam int unsigned SHORT_W  = 8;
    localparam int unsigned STEP_W   = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 14;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CMD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHAR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_POS  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TWO_LINES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_WAIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WAIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_WAIT = 2'd3;

    // Register reset values
    localparam logic               RST_TWO_LINES  = 1'b1;
    localparam logic [WAIT_W-1:0]  RST_POWER_WAIT = 14'd15000;
    localparam logic [LONG_W-1:0]  RST_LONG_WAIT  = 12'd1600;
    localparam logic [SHORT_W-1:0] RST_SHORT_WAIT = 8'd43;

    // Command codes and init nibbles
    localparam logic [BYTE_W-1:0] CMD_FSET_2L   = 8'h28;
    localparam logic [BYTE_W-1:0] CMD_FSET_1L   = 8'h20;
    localparam logic [BYTE_W-1:0] CMD_CLEAR     = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_ENTRY     = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [BYTE_W-1:0] CMD_SET_ADDR  = 8'h80;
    localparam logic [BYTE_W-1:0] LONG_CMD_MASK = 8'hFC;
    localparam logic [NIB_W-1:0]  NIB_INIT_8BIT = 4'h3;
    localparam logic [NIB_W-1:0]  NIB_INIT_4BIT = 4'h2;

    // Fixed init waits in ticks
    localparam logic [WAIT_W-1:0] WAIT_INIT_FIRST = 14'd4100;
    localparam logic [WAIT_W-1:0] WAIT_INIT_REST  = 14'd120;

    // Init sequence steps
    localparam logic [STEP_W-1:0] STEP_NIB_LAST = 4'd2;
    localparam logic [STEP_W-1:0] STEP_NIB_4BIT = 4'd3;
    localparam logic [STEP_W-1:0] STEP_FSET     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_CLEAR    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_ENTRY    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DISP_ON  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DONE     = 4'd8;

    typedef struct packed {
        logic               two_lines;
        logic [WAIT_W-1:0]  power_wait;
        logic [LONG_W-1:0]  long_wait;
        logic [SHORT_W-1:0] short_wait;
    } t_cfg;

    typedef struct packed {
        logic             pin_e;
        logic             pin_rs;
        logic [NIB_W-1:0] pin_data;
        logic             ready_res;
        logic             rejected;
    } t_result;

    // DDRAM offset of each display row
    function automatic logic [BYTE_W-1:0] row_offset(input logic [ROW_W-1:0] row);
        logic [BYTE_W-1:0] off;
        case (row)
            2'd0:    off = 8'd0;
            2'd1:    off = 8'd64;
            2'd2:    off = 8'd20;
            default: off = 8'd84;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cln_if.sv =====
// Handshake channel interfaces: request input, pin-state output, register writes.
// Depends on cln_pkg for field widths.
`default_nettype none

interface cln_in_if;
    logic                          valid;
    logic                          ready;
    logic [cln_pkg::FUNC_W-1:0]    func;
    logic [cln_pkg::BYTE_W-1:0]    data_byte;
    logic [cln_pkg::COL_W-1:0]     column;
    logic [cln_pkg::ROW_W-1:0]     row;

    modport source (output valid, func, data_byte, column, row, input ready);
    modport sink   (input valid, func, data_byte, column, row, output ready);
endinterface

interface cln_out_if;
    logic                       valid;
    logic                       ready;
    logic                       pin_e;
    logic                       pin_rs;
    logic [cln_pkg::NIB_W-1:0]  pin_data;
    logic                       ready_res;
    logic                       rejected;

    modport source (output valid, pin_e, pin_rs, pin_data, ready_res, rejected,
                    input ready);
    modport sink   (input valid, pin_e, pin_rs, pin_data, ready_res, rejected,
                    output ready);
endinterface

interface cln_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cln_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [cln_pkg::CFG_DATA_W-1:0]  wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/cln_seq.sv =====
// LCD sequencer: power-up wait, init sequence, nibble strobing and command waits.
// Advances one item per i_step; depends on cln_pkg.
`default_nettype none

module cln_seq (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire logic [cln_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [cln_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic [cln_pkg::COL_W-1:0]    i_column,
    input  wire logic [cln_pkg::ROW_W-1:0]    i_row,
    input  wire cln_pkg::t_cfg                i_cfg,
    output cln_pkg::t_result                  o_res
);

    localparam logic [2:0] PH_POWER = 3'd0;
    localparam logic [2:0] PH_EHIGH = 3'd1;
    localparam logic [2:0] PH_ELOW  = 3'd2;
    localparam logic [2:0] PH_WAIT  = 3'd3;
    localparam logic [2:0] PH_IDLE  = 3'd4;

    logic [2:0]                    r_phase, n_phase;
    logic [cln_pkg::WAIT_W-1:0]    r_wait, n_wait;
    logic [cln_pkg::BYTE_W-1:0]    r_pending, n_pending;
    logic                          r_low_next, n_low_next;
    logic                          r_rs, n_rs;
    logic [cln_pkg::STEP_W-1:0]    r_init_step, n_init_step;
    logic                          r_e, n_e;
    logic [cln_pkg::NIB_W-1:0]     r_data, n_data;

    logic                          rejected;
    logic                          do_init;
    logic [cln_pkg::STEP_W-1:0]    init_sel;
    logic [cln_pkg::WAIT_W-1:0]    wait_inc;
    logic [cln_pkg::WAIT_W-1:0]    wait_after;
    logic [cln_pkg::BYTE_W-1:0]    req_byte;
    logic [cln_pkg::BYTE_W-1:0]    pos_sum;
    logic [cln_pkg::BYTE_W-1:0]    init_byte;

    // Saturating power-up tick count
    assign wait_inc = (r_wait != '1) ? r_wait + 1'b1 : r_wait;

    // Wait that follows the current nibble or byte
    always_comb begin
        if (r_init_step < cln_pkg::STEP_FSET) begin
            wait_after = (r_init_step == '0) ? cln_pkg::WAIT_INIT_FIRST
                                              : cln_pkg::WAIT_INIT_REST;
        end else if (!r_rs && ((r_pending & cln_pkg::LONG_CMD_MASK) == '0)) begin
            wait_after = {{(cln_pkg::WAIT_W-cln_pkg::LONG_W){1'b0}}, i_cfg.long_wait};
        end else begin
            wait_after = {{(cln_pkg::WAIT_W-cln_pkg::SHORT_W){1'b0}}, i_cfg.short_wait};
        end
    end

    // Byte for an accepted request
    assign pos_sum = cln_pkg::row_offset(i_row)
                   + {{(cln_pkg::BYTE_W-cln_pkg::COL_W){1'b0}}, i_column};
    assign req_byte = (i_func == cln_pkg::FUNC_POS) ? (pos_sum | cln_pkg::CMD_SET_ADDR)
                                                    : i_data_byte;

    // Command byte of an init step
    always_comb begin
        case (init_sel)
            cln_pkg::STEP_FSET:  init_byte = i_cfg.two_lines ? cln_pkg::CMD_FSET_2L
                                                             : cln_pkg::CMD_FSET_1L;
            cln_pkg::STEP_CLEAR: init_byte = cln_pkg::CMD_CLEAR;
            cln_pkg::STEP_ENTRY: init_byte = cln_pkg::CMD_ENTRY;
            default:             init_byte = cln_pkg::CMD_DISP_ON;
        endcase
    end

    // Next state for one item
    always_comb begin
        n_phase     = r_phase;
        n_wait      = r_wait;
        n_pending   = r_pending;
        n_low_next  = r_low_next;
        n_rs        = r_rs;
        n_init_step = r_init_step;
        n_e         = r_e;
        n_data      = r_data;
        rejected    = 1'b0;
        do_init     = 1'b0;
        init_sel    = r_init_step;

        if (i_func == cln_pkg::FUNC_TICK) begin
            case (r_phase)
                PH_POWER: begin
                    if (wait_inc >= i_cfg.power_wait) begin
                        n_wait      = '0;
                        n_init_step = '0;
                        init_sel    = '0;
                        do_init     = 1'b1;
                    end else begin
                        n_wait = wait_inc;
                    end
                end
                PH_EHIGH: begin
                    n_e     = 1'b0;
                    n_phase = PH_ELOW;
                end
                PH_ELOW: begin
                    if (r_low_next) begin
                        n_data     = r_pending[cln_pkg::NIB_W-1:0];
                        n_e        = 1'b1;
                        n_low_next = 1'b0;
                        n_phase    = PH_EHIGH;
                    end else begin
                        n_wait  = wait_after;
                        n_phase = PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    if (r_wait > 14'd1) begin
                        n_wait = r_wait - 1'b1;
                    end else begin
                        n_wait = '0;
                        if (r_init_step < cln_pkg::STEP_DONE) begin
                            n_init_step = r_init_step + 1'b1;
                            init_sel    = r_init_step + 1'b1;
                            do_init     = 1'b1;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end else if (r_phase != PH_IDLE) begin
            // drop requests while busy
            rejected = 1'b1;
        end else begin
            n_pending  = req_byte;
            n_rs       = (i_func == cln_pkg::FUNC_CHAR);
            n_data     = req_byte[cln_pkg::BYTE_W-1:cln_pkg::NIB_W];
            n_e        = 1'b1;
            n_low_next = 1'b1;
            n_phase    = PH_EHIGH;
        end

        // Launch the selected init step
        if (do_init) begin
            if (init_sel <= cln_pkg::STEP_NIB_4BIT) begin
                n_rs       = 1'b0;
                n_data     = (init_sel <= cln_pkg::STEP_NIB_LAST) ? cln_pkg::NIB_INIT_8BIT
                                                                  : cln_pkg::NIB_INIT_4BIT;
                n_e        = 1'b1;
                n_low_next = 1'b0;
                n_phase    = PH_EHIGH;
            end else if (init_sel < cln_pkg::STEP_DONE) begin
                n_pending  = init_byte;
                n_rs       = 1'b0;
                n_data     = init_byte[cln_pkg::BYTE_W-1:cln_pkg::NIB_W];
                n_e        = 1'b1;
                n_low_next = 1'b1;
                n_phase    = PH_EHIGH;
            end else begin
                n_phase = PH_IDLE;
            end
        end
    end

    // Result of this item
    always_comb begin
        o_res.pin_e     = n_e;
        o_res.pin_rs    = n_rs;
        o_res.pin_data  = n_data;
        o_res.ready_res = (n_phase == PH_IDLE);
        o_res.rejected  = rejected;
    end

    // Advance state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_POWER;
            r_wait      <= '0;
            r_pending   <= '0;
            r_low_next  <= 1'b0;
            r_rs        <= 1'b0;
            r_init_step <= '0;
            r_e         <= 1'b0;
            r_data      <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_wait      <= n_wait;
            r_pending   <= n_pending;
            r_low_next  <= n_low_next;
            r_rs        <= n_rs;
            r_init_step <= n_init_step;
            r_e         <= n_e;
            r_data      <= n_data;
        end
    end

    // E is high exactly while the strobe-high phase holds
    a_e_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EHIGH) == r_e)
        else $error("E level out of step with strobe phase");

    // Busy requests leave the sequencer untouched
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_func != cln_pkg::FUNC_TICK) && (r_phase != PH_IDLE))
        |=> ($stable(r_phase) && $stable(r_pending) && $stable(r_wait) && $stable(r_rs)))
        else $error("dropped request changed sequencer state");

    // Idle only once the init sequence has finished
    a_idle_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_init_step == cln_pkg::STEP_DONE))
        else $error("idle before init sequence completed");

    // Init step never runs past its end
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init_step <= cln_pkg::STEP_DONE)
        else $error("init step out of range");

endmodule

`default_nettype wire

// ===== rtl/char_lcd_nibble_interface_top.sv =====
// Character LCD 4-bit interface: top level with register bank and output stage.
// Depends on cln_pkg, cln_if.sv and cln_seq.
//
// Usage:
//   i_in  carries items: a one-microsecond tick (func 0) or a request
//         (func 1 command, 2 character, 3 set cursor position).
//   o_out returns one item per input item: the E, RS and D4..D7 pin levels
//         after that item, ready_res (idle, a request would be taken) and
//         rejected (request dropped because the controller was busy).
//   i_cfg writes the two_lines, power_wait_us, long_wait_us and
//         short_wait_us registers; always ready, write only while idle.
// Timing: one item per cycle sustained while results are taken; each result
//   appears in the output register in the cycle after its item is accepted. The
//   sequencer state and a single result register are the only storage; no other buffering.
// Reset: registers return to their defaults and the sequencer starts the
//   power-up wait, then the init nibbles and commands, paced by ticks.
// Stall: while the output register holds an untaken result, a new item is
//   accepted only in a cycle where that result is taken.
`default_nettype none

module char_lcd_nibble_interface_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cln_in_if.sink     i_in,
    cln_out_if.source  o_out,
    cln_cfg_if.sink    i_cfg
);

    cln_pkg::t_cfg     r_cfg;
    cln_pkg::t_result  seq_res;
    cln_pkg::t_result  r_res;
    logic              r_out_valid;
    logic              in_accept;

    // Take a new item whenever the output slot is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.two_lines  <= cln_pkg::RST_TWO_LINES;
            r_cfg.power_wait <= cln_pkg::RST_POWER_WAIT;
            r_cfg.long_wait  <= cln_pkg::RST_LONG_WAIT;
            r_cfg.short_wait <= cln_pkg::RST_SHORT_WAIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                cln_pkg::REG_TWO_LINES:  r_cfg.two_lines  <= i_cfg.wdata[0];
                cln_pkg::REG_POWER_WAIT: r_cfg.power_wait <= i_cfg.wdata;
                cln_pkg::REG_LONG_WAIT:
                    r_cfg.long_wait  <= i_cfg.wdata[cln_pkg::LONG_W-1:0];
                cln_pkg::REG_SHORT_WAIT:
                    r_cfg.short_wait <= i_cfg.wdata[cln_pkg::SHORT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cln_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_accept),
        .i_func      (i_in.func),
        .i_data_byte (i_in.data_byte),
        .i_column    (i_in.column),
        .i_row       (i_in.row),
        .i_cfg       (r_cfg),
        .o_res       (seq_res)
    );

    // Output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= seq_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.pin_e     = r_res.pin_e;
    assign o_out.pin_rs    = r_res.pin_rs;
    assign o_out.pin_data  = r_res.pin_data;
    assign o_out.ready_res = r_res.ready_res;
    assign o_out.rejected  = r_res.rejected;

    // A held result is not overwritten while stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !in_accept)
        else $error("result overwritten while stalled");

    // Every accepted item yields a pending result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted item produced no result");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for the character LCD 4-bit interface: drives ticks and requests,
// predicts the pin levels of every item and checks them against the block.
// Depends on rtl/cln_pkg.sv, rtl/cln_if.sv and the char_lcd_nibble_interface_top RTL.
`timescale 1ns / 1ps

module testbench;
    import cln_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_BUDGET  = 210;
    localparam int NORMAL_PHASES = 5;
    localparam int PRINT_CAP     = 40;
    localparam int EARLY_TICKS   = 2000;
    localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;

    typedef enum logic [2:0] {
        SEQ_POWER_UP, SEQ_E_HIGH, SEQ_E_LOW, SEQ_HOLD, SEQ_IDLE
    } seq_phase_e;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] data_byte;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } lcd_req_t;

    logic i_clk;
    logic i_rst_n;

    cln_in_if  req_if ();
    cln_out_if pin_if ();
    cln_cfg_if cfg_if ();

    char_lcd_nibble_interface_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (pin_if),
        .i_cfg   (cfg_if)
    );

    // Shadow of the controller: registers and sequencer state
    t_cfg              lcd_cfg;
    seq_phase_e        seq_phase;
    logic [WAIT_W-1:0] hold_count;
    logic [BYTE_W-1:0] cur_byte;
    logic              low_nib_pending;
    logic              rs_q;
    logic [STEP_W-1:0] init_idx;
    logic              e_q;
    logic [NIB_W-1:0]  nib_q;

    lcd_req_t pending_reqs [$];
    t_result  pin_levels_q [$];

    int  lcd_items_queued;
    int  lcd_results_seen;
    int  mismatch_count;
    int  n_taken;
    int  n_dropped;
    int  n_ticks;
    int  n_phases;
    int  idle_cycles;
    bit  req_taken;
    int  req_gap;
    int  req_calm;
    int  rsp_hold;
    int  rsp_calm;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones, and now and then a run with none
    function automatic int next_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(30, 100);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) $display("ERROR: %s", msg);
    endtask

    function automatic void launch_nibble(input logic [NIB_W-1:0] nib);
        rs_q = 1'b0;
        nib_q = nib;
        e_q = 1'b1;
        low_nib_pending = 1'b0;
        seq_phase = SEQ_E_HIGH;
    endfunction

    function automatic void launch_byte(input logic [BYTE_W-1:0] b, input logic rs);
        cur_byte = b;
        rs_q = rs;
        nib_q = b[7:4];
        e_q = 1'b1;
        low_nib_pending = 1'b1;
        seq_phase = SEQ_E_HIGH;
    endfunction

    function automatic void launch_init_step();
        if (init_idx <= STEP_NIB_LAST) begin
            launch_nibble(NIB_INIT_8BIT);
        end else begin
            case (init_idx)
                STEP_NIB_4BIT: launch_nibble(NIB_INIT_4BIT);
                STEP_FSET:     launch_byte(lcd_cfg.two_lines ? CMD_FSET_2L : CMD_FSET_1L, 1'b0);
                STEP_CLEAR:    launch_byte(CMD_CLEAR, 1'b0);
                STEP_ENTRY:    launch_byte(CMD_ENTRY, 1'b0);
                STEP_DISP_ON:  launch_byte(CMD_DISP_ON, 1'b0);
                default:       seq_phase = SEQ_IDLE;
            endcase
        end
    endfunction

    // Advance the shadow controller by one item and return the pin levels after it
    function automatic t_result lcd_pin_step(input lcd_req_t rq);
        t_result           r;
        logic [BYTE_W-1:0] base;
        logic              rej;
        rej = 1'b0;
        if (rq.func == FUNC_TICK) begin
            case (seq_phase)
                SEQ_POWER_UP: begin
                    if (hold_count < {WAIT_W{1'b1}}) hold_count = hold_count + 1'b1;
                    if (hold_count >= lcd_cfg.power_wait) begin
                        hold_count = '0;
                        init_idx = STEP_FIRST;
                        launch_init_step();
                    end
                end
                SEQ_E_HIGH: begin
                    e_q = 1'b0;
                    seq_phase = SEQ_E_LOW;
                end
                SEQ_E_LOW: begin
                    if (low_nib_pending) begin
                        nib_q = cur_byte[3:0];
                        e_q = 1'b1;
                        low_nib_pending = 1'b0;
                        seq_phase = SEQ_E_HIGH;
                    end else begin
                        // Clear and home commands get the long wait
                        if (init_idx < STEP_FSET)
                            hold_count = (init_idx == STEP_FIRST) ? WAIT_INIT_FIRST
                                                                  : WAIT_INIT_REST;
                        else if (!rs_q && (cur_byte & LONG_CMD_MASK) == '0)
                            hold_count = WAIT_W'(lcd_cfg.long_wait);
                        else
                            hold_count = WAIT_W'(lcd_cfg.short_wait);
                        seq_phase = SEQ_HOLD;
                    end
                end
                SEQ_HOLD: begin
                    if (hold_count > 1) begin
                        hold_count = hold_count - 1'b1;
                    end else begin
                        hold_count = '0;
                        if (init_idx < STEP_DONE) begin
                            init_idx = init_idx + 1'b1;
                            launch_init_step();
                        end else begin
                            seq_phase = SEQ_IDLE;
                        end
                    end
                end
                default: seq_phase = SEQ_IDLE;
            endcase
        end else if (seq_phase != SEQ_IDLE) begin
            rej = 1'b1;
        end else if (rq.func == FUNC_CMD) begin
            launch_byte(rq.data_byte, 1'b0);
        end else if (rq.func == FUNC_CHAR) begin
            launch_byte(rq.data_byte, 1'b1);
        end else begin
            case (rq.row)
                2'd0:    base = 8'd0;
                2'd1:    base = 8'd64;
                2'd2:    base = 8'd20;
                default: base = 8'd84;
            endcase
            launch_byte((base + {2'b00, rq.column}) | CMD_SET_ADDR, 1'b0);
        end
        r.pin_e = e_q;
        r.pin_rs = rs_q;
        r.pin_data = nib_q;
        r.ready_res = (seq_phase == SEQ_IDLE);
        r.rejected = rej;
        return r;
    endfunction

    function automatic lcd_req_t make_req(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b,
                                          input logic [COL_W-1:0] c, input logic [ROW_W-1:0] rw);
        lcd_req_t q;
        q.func = f;
        q.data_byte = b;
        q.column = c;
        q.row = rw;
        return q;
    endfunction

    function automatic lcd_req_t random_request();
        logic [FUNC_W-1:0] f;
        logic [BYTE_W-1:0] b;
        f = FUNC_W'($urandom_range(1, 3));
        if (f == FUNC_CMD && $urandom_range(0, 9) < 3) b = BYTE_W'($urandom_range(0, 3));
        else b = BYTE_W'($urandom_range(0, 255));
        return make_req(f, b, COL_W'($urandom_range(0, 63)), ROW_W'($urandom_range(0, 3)));
    endfunction

    // Ticks a request keeps the controller busy, given the current waits
    function automatic int busy_ticks(input lcd_req_t rq);
        int w;
        if (rq.func == FUNC_CMD && (rq.data_byte & LONG_CMD_MASK) == '0)
            w = int'(lcd_cfg.long_wait);
        else
            w = int'(lcd_cfg.short_wait);
        return 4 + ((w > 1) ? w : 1);
    endfunction

    task automatic queue_item(input lcd_req_t rq);
        pending_reqs.push_back(rq);
        lcd_items_queued++;
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) queue_item(make_req(FUNC_TICK, BYTE_W'($urandom_range(0, 255)),
                                       COL_W'($urandom_range(0, 63)),
                                       ROW_W'($urandom_range(0, 3))));
    endtask

    // Request, its busy ticks, and a busy request dropped in after split ticks
    task automatic queue_sequence(input lcd_req_t rq, input int split, output int used);
        int n;
        n = busy_ticks(rq);
        queue_item(rq);
        if (split < n) begin
            queue_ticks(split);
            queue_item(random_request());
            queue_ticks(n - split);
            used = n + 2;
        end else begin
            queue_ticks(n);
            used = n + 1;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wdata <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_all(input logic two, input int pwr, input int lng, input int sht);
        write_reg(REG_TWO_LINES, CFG_DATA_W'(two));
        write_reg(REG_POWER_WAIT, CFG_DATA_W'(pwr));
        write_reg(REG_LONG_WAIT, CFG_DATA_W'(lng));
        write_reg(REG_SHORT_WAIT, CFG_DATA_W'(sht));
        n_phases++;
    endtask

    // Hold until every queued item has its result back
    task automatic settle();
        while (lcd_results_seen != lcd_items_queued) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int budget);
        int used;
        int n;
        int split;
        int step;
        lcd_req_t rq;
        used = 0;
        while (used < budget) begin
            rq = random_request();
            n = busy_ticks(rq);
            split = ($urandom_range(0, 99) < 20) ? $urandom_range(0, n - 1) : n;
            queue_sequence(rq, split, step);
            used += step;
            if ($urandom_range(0, 99) < 30) queue_ticks($urandom_range(1, 3));
        end
    endtask

    // Drive the request channel at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && (!req_if.valid || req_taken)) begin
            req_taken = 1'b0;
            if (req_gap > 0) begin
                req_gap--;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                req_if.valid <= 1'b1;
                req_if.func <= pending_reqs[0].func;
                req_if.data_byte <= pending_reqs[0].data_byte;
                req_if.column <= pending_reqs[0].column;
                req_if.row <= pending_reqs[0].row;
                void'(pending_reqs.pop_front());
                req_gap = next_gap(req_calm);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Stall the result channel at random
    always @(negedge i_clk) begin
        if (rsp_hold > 0) begin
            rsp_hold--;
            pin_if.ready <= 1'b0;
        end else begin
            pin_if.ready <= 1'b1;
            rsp_hold = next_gap(rsp_calm);
        end
    end

    // Check results, predict accepted items, track register writes, watch for hangs
    always @(posedge i_clk) begin : pin_monitor
        lcd_req_t rq;
        t_result  want;
        bit       moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (pin_if.valid && pin_if.ready) begin
                moved = 1'b1;
                if (pin_levels_q.size() == 0) begin
                    note_mismatch($sformatf("result %0d arrived with nothing pending",
                                            lcd_results_seen));
                end else begin
                    want = pin_levels_q.pop_front();
                    if (pin_if.pin_e !== want.pin_e)
                        note_mismatch($sformatf("result %0d pin_e %b want %b",
                                                lcd_results_seen, pin_if.pin_e, want.pin_e));
                    if (pin_if.pin_rs !== want.pin_rs)
                        note_mismatch($sformatf("result %0d pin_rs %b want %b",
                                                lcd_results_seen, pin_if.pin_rs, want.pin_rs));
                    if (pin_if.pin_data !== want.pin_data)
                        note_mismatch($sformatf("result %0d pin_data %h want %h",
                                                lcd_results_seen, pin_if.pin_data, want.pin_data));
                    if (pin_if.ready_res !== want.ready_res)
                        note_mismatch($sformatf("result %0d ready_res %b want %b", lcd_results_seen,
                                                pin_if.ready_res, want.ready_res));
                    if (pin_if.rejected !== want.rejected)
                        note_mismatch($sformatf("result %0d rejected %b want %b", lcd_results_seen,
                                                pin_if.rejected, want.rejected));
                end
                lcd_results_seen++;
            end
            if (req_if.valid && req_if.ready) begin
                moved = 1'b1;
                req_taken = 1'b1;
                rq = make_req(req_if.func, req_if.data_byte, req_if.column, req_if.row);
                want = lcd_pin_step(rq);
                pin_levels_q.push_back(want);
                if (rq.func == FUNC_TICK) n_ticks++;
                else if (want.rejected) n_dropped++;
                else n_taken++;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                moved = 1'b1;
                case (cfg_if.reg_index)
                    REG_TWO_LINES:  lcd_cfg.two_lines = cfg_if.wdata[0];
                    REG_POWER_WAIT: lcd_cfg.power_wait = cfg_if.wdata[WAIT_W-1:0];
                    REG_LONG_WAIT:  lcd_cfg.long_wait = cfg_if.wdata[LONG_W-1:0];
                    default:        lcd_cfg.short_wait = cfg_if.wdata[SHORT_W-1:0];
                endcase
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int used;
        int init_len;
        int p;
        lcd_req_t rq;

        // Known levels on every input from time zero
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.func = FUNC_TICK;
        req_if.data_byte = '0;
        req_if.column = '0;
        req_if.row = '0;
        pin_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.reg_index = REG_TWO_LINES;
        cfg_if.wdata = '0;
        req_taken = 1'b0;
        req_gap = 0;
        req_calm = 0;
        rsp_hold = 0;
        rsp_calm = 0;
        idle_cycles = 0;
        lcd_items_queued = 0;
        lcd_results_seen = 0;
        mismatch_count = 0;
        n_taken = 0;
        n_dropped = 0;
        n_ticks = 0;
        n_phases = 0;

        // Shadow state after reset
        lcd_cfg.two_lines = RST_TWO_LINES;
        lcd_cfg.power_wait = RST_POWER_WAIT;
        lcd_cfg.long_wait = RST_LONG_WAIT;
        lcd_cfg.short_wait = RST_SHORT_WAIT;
        seq_phase = SEQ_POWER_UP;
        hold_count = '0;
        cur_byte = '0;
        low_nib_pending = 1'b0;
        rs_q = 1'b0;
        init_idx = STEP_FIRST;
        e_q = 1'b0;
        nib_q = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero power wait: init starts on the very first tick
        write_all(1'b0, 0, 5, 1);

        // Requests during power-up and init are dropped
        queue_item(make_req(FUNC_CMD, 8'h01, 6'd0, 2'd0));
        init_len = 1 + 2 + int'(WAIT_INIT_FIRST) + 3 * (2 + int'(WAIT_INIT_REST))
                 + busy_ticks(make_req(FUNC_CMD, CMD_CLEAR, '0, '0))
                 + 3 * busy_ticks(make_req(FUNC_CMD, CMD_ENTRY, '0, '0));
        queue_ticks(1);
        queue_item(make_req(FUNC_CHAR, 8'h41, 6'd0, 2'd0));
        queue_ticks(EARLY_TICKS);
        queue_item(make_req(FUNC_POS, 8'h00, 6'd39, 2'd3));
        queue_ticks(init_len - 1 - EARLY_TICKS + 2);

        // Directed requests: long and short command edges, field extremes
        queue_sequence(make_req(FUNC_CMD, 8'h00, 6'd0, 2'd0), 1000, used);
        queue_sequence(make_req(FUNC_CMD, 8'h03, 6'd0, 2'd0), 1000, used);
        queue_sequence(make_req(FUNC_CMD, 8'h04, 6'd0, 2'd0), 1000, used);
        queue_sequence(make_req(FUNC_CMD, 8'hFF, 6'd63, 2'd3), 1000, used);
        queue_sequence(make_req(FUNC_CHAR, 8'h00, 6'd0, 2'd0), 1000, used);
        queue_sequence(make_req(FUNC_CHAR, 8'hFF, 6'd0, 2'd0), 2, used);
        queue_sequence(make_req(FUNC_POS, 8'h00, 6'd0, 2'd0), 1000, used);
        queue_sequence(make_req(FUNC_POS, 8'hFF, 6'd63, 2'd3), 1000, used);
        queue_sequence(make_req(FUNC_POS, 8'h00, 6'd39, 2'd1), 0, used);
        queue_sequence(make_req(FUNC_POS, 8'h00, 6'd42, 2'd2), 1000, used);
        queue_ticks(2);
        settle();

        // Random phases: zero waits, unit waits, then assorted small waits
        for (p = 0; p < NORMAL_PHASES; p++) begin
            case (p)
                0:       write_all(1'b1, {WAIT_W{1'b1}}, 0, 0);
                1:       write_all(1'b0, $urandom_range(0, 16383), 1, 1);
                default: write_all(p[0], $urandom_range(0, 16383),
                                   $urandom_range(2, 24), $urandom_range(2, 16));
            endcase
            run_random_phase(PHASE_BUDGET);
            settle();
        end

        // Full-scale waits: a few requests only
        write_all(1'b1, 0, {LONG_W{1'b1}}, {SHORT_W{1'b1}});
        rq = make_req(FUNC_CMD, BYTE_W'($urandom_range(0, 3)), '0, '0);
        queue_sequence(rq, $urandom_range(0, 4000), used);
        queue_sequence(make_req(FUNC_CHAR, BYTE_W'($urandom_range(0, 255)), '0, '0), 1000, used);
        queue_sequence(make_req(FUNC_POS, '0, COL_W'($urandom_range(0, 63)),
                                ROW_W'($urandom_range(0, 3))),
                       $urandom_range(0, 200), used);
        queue_ticks(3);
        settle();

        if (pin_levels_q.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pin_levels_q.size()));

        $display("run covered %0d items: %0d requests taken, %0d dropped as busy, %0d ticks",
                 lcd_items_queued, n_taken, n_dropped, n_ticks);
        $display("%0d register settings, waits from zero to full scale; %0d mismatches",
                 n_phases, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
